// ----- hw/rtl/ttce_pkg.sv -----
package ttce_pkg;

	localparam int CODE_W = 7;
	localparam int COLOUR_W = 3;
	localparam int CELL_W = CODE_W + 2 * COLOUR_W;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 5;

	localparam logic [2:0] REQ_BYTE = 3'd0;
	localparam logic [2:0] REQ_HOME = 3'd1;
	localparam logic [2:0] REQ_CLEAR = 3'd2;
	localparam logic [2:0] REQ_CLEAR_LINE = 3'd3;
	localparam logic [2:0] REQ_SET_ROW = 3'd4;
	localparam logic [2:0] REQ_SET_COL = 3'd5;
	localparam logic [2:0] REQ_READ = 3'd6;

	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [CODE_W-1:0] BLANK = 7'd32;
	localparam logic [3:0] MAX_DIGIT = 4'd9;

	localparam logic [CFG_AW-1:0] CFG_TEXT = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_BACK = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_LIMIT = 2'd2;

	localparam logic [COLOUR_W-1:0] RESET_FORE = 3'd7;
	localparam logic [COLOUR_W-1:0] RESET_BACK = 3'd0;
	localparam logic [CFG_DW-1:0] RESET_LIMIT = 5'd24;

	typedef struct packed {
		logic [COLOUR_W-1:0] back;
		logic [COLOUR_W-1:0] fore;
		logic [CODE_W-1:0] code;
	} cell_t;

	function automatic cell_t make_cell(input logic [CODE_W-1:0] code,
			input logic [COLOUR_W-1:0] fore, input logic [COLOUR_W-1:0] back);
		cell_t c;
		c.code = code;
		c.fore = fore;
		c.back = back;
		return c;
	endfunction

endpackage

// ----- hw/rtl/text_terminal_cell_engine.sv -----
// Byte, home, set row, set column and no-op beats give their result in the cycle after
// acceptance; a cell read passes the RAM's registered read data, then the output register.
// Non-scrolling byte, home, set row, set column and no-op beats sustain one per cycle while out_ready is high.
// A scroll adds a row fill, clear line a read-modify-write, and clear screen a fill, all on the
// single write port of the cell RAM. Reset is asynchronous; afterwards a clearing pass fills
// the RAM with blanks while in_ready stays low. Configuration writes are taken at any time.
module text_terminal_cell_engine #(
	parameter int ROWS = 24,
	parameter int COLS = 80
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ttce_pkg::CFG_AW-1:0] cfg_addr,
	input logic [ttce_pkg::CFG_DW-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] req_type,
	input logic [7:0] char_code,
	input logic [3:0] digit,
	input logic [4:0] read_row,
	input logic [6:0] read_col,
	output logic out_valid,
	input logic out_ready,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_col,
	output logic [6:0] cell_code,
	output logic [2:0] cell_fore,
	output logic [2:0] cell_back,
	output logic did_scroll
);

	localparam int YW = $clog2(ROWS);
	localparam int YW1 = YW + 1;
	localparam int XW = $clog2(COLS + 1);
	localparam int LW = $clog2(ROWS + 1);
	localparam int DEPTH = ROWS * COLS;
	localparam int AW = $clog2(DEPTH);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_FILL = 3'd2;
	localparam logic [2:0] S_CLRL = 3'd3;
	localparam logic [2:0] S_READ = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] row,
			input logic [YW-1:0] top, input logic [XW-1:0] col);
		logic [YW:0] sum;
		sum = {1'b0, row} + {1'b0, top};
		if (sum >= YW1'(ROWS)) begin
			sum = sum - YW1'(ROWS);
		end
		return AW'(sum) * AW'(COLS) + AW'(col);
	endfunction

	logic [2:0] state_q;
	logic [XW-1:0] cur_x_q;
	logic [YW-1:0] cur_y_q;
	logic [YW-1:0] top_q;
	logic [2:0] text_q;
	logic [2:0] back_q;
	logic [4:0] limit_q;
	logic [AW-1:0] sw_addr_q;
	logic [AW-1:0] sw_end_q;
	ttce_pkg::cell_t fill_q;
	logic rd_done_q;
	logic vld_s1;
	logic [AW-1:0] addr_s1;
	logic pend_we_q;
	logic pend_scroll_q;
	logic rd_ok_q;
	logic [AW-1:0] pend_addr_q;
	ttce_pkg::cell_t pend_data_q;
	logic out_valid_q;
	logic [4:0] out_row_q;
	logic [6:0] out_col_q;
	logic [6:0] out_code_q;
	logic [2:0] out_fore_q;
	logic [2:0] out_back_q;
	logic out_scroll_q;

	logic accept;
	logic [LW-1:0] lim_eff;
	logic [YW-1:0] top_inc;
	logic [XW-1:0] bt_x;
	logic [XW-1:0] bt_nx;
	logic [LW-1:0] bt_y1;
	logic [YW-1:0] bt_y;
	logic [YW-1:0] bt_top;
	logic bt_chk;
	logic bt_print;
	logic bt_scroll;
	logic [AW-1:0] bt_addr;
	logic [XW-1:0] im_x;
	logic [YW-1:0] im_y;
	logic [YW-1:0] im_top;
	logic rd_ok;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] cl_base;
	logic [AW-1:0] sc_base;
	ttce_pkg::cell_t new_blank;
	ttce_pkg::cell_t rd_cell;
	logic [ttce_pkg::CELL_W-1:0] ram_rdata;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	ttce_pkg::cell_t ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic immediate;
	logic ld_en;
	logic [4:0] ld_row;
	logic [6:0] ld_col;
	logic [6:0] ld_code;
	logic [2:0] ld_fore;
	logic [2:0] ld_back;
	logic ld_scroll;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign new_blank = ttce_pkg::make_cell(ttce_pkg::BLANK, text_q, back_q);
	assign rd_cell = ttce_pkg::cell_t'(ram_rdata);
	assign cl_base = cell_addr(cur_y_q, top_q, '0);
	assign sc_base = cell_addr(top_q, '0, '0);
	assign top_inc = (32'(top_q) == 32'(ROWS - 1)) ? '0 : top_q + YW'(1);

	always_comb begin
		if (limit_q == '0) begin
			lim_eff = LW'(1);
		end else if (32'(limit_q) > 32'(ROWS)) begin
			lim_eff = LW'(ROWS);
		end else begin
			lim_eff = LW'(limit_q);
		end
	end

	always_comb begin
		bt_x = cur_x_q;
		bt_y1 = LW'(cur_y_q);
		bt_chk = 1'b0;
		bt_print = 1'b0;
		case (char_code)
			ttce_pkg::CH_NL: begin
				bt_x = '0;
				bt_y1 = LW'(cur_y_q) + LW'(1);
				bt_chk = 1'b1;
			end
			ttce_pkg::CH_CR: begin
				bt_x = '0;
			end
			ttce_pkg::CH_BS: begin
				if (cur_x_q != '0) begin
					bt_x = cur_x_q - XW'(1);
				end
			end
			default: begin
				if (cur_x_q >= XW'(COLS)) begin
					bt_x = '0;
					bt_y1 = LW'(cur_y_q) + LW'(1);
				end
				bt_chk = 1'b1;
				bt_print = !char_code[7] && (char_code[6:5] != 2'b00);
			end
		endcase
		bt_scroll = bt_chk && (bt_y1 >= lim_eff);
		bt_y = bt_scroll ? YW'(lim_eff - LW'(1)) : YW'(bt_y1);
		bt_top = bt_scroll ? top_inc : top_q;
		bt_addr = cell_addr(bt_y, bt_top, bt_x);
		bt_nx = bt_print ? bt_x + XW'(1) : bt_x;
	end

	always_comb begin
		im_x = cur_x_q;
		im_y = cur_y_q;
		im_top = top_q;
		case (req_type)
			ttce_pkg::REQ_BYTE: begin
				im_x = bt_nx;
				im_y = bt_y;
				im_top = bt_top;
			end
			ttce_pkg::REQ_HOME: begin
				im_x = '0;
				im_y = '0;
			end
			ttce_pkg::REQ_SET_ROW: begin
				if (digit <= ttce_pkg::MAX_DIGIT && 32'(digit) < 32'(ROWS)) begin
					im_y = YW'(digit);
				end
			end
			ttce_pkg::REQ_SET_COL: begin
				if (digit <= ttce_pkg::MAX_DIGIT && 32'(digit) < 32'(COLS)) begin
					im_x = XW'(digit);
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_ok = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLS));
	assign rd_addr = rd_ok ? cell_addr(YW'(read_row), top_q, XW'(read_col)) : '0;

	always_comb begin
		case (req_type)
			ttce_pkg::REQ_CLEAR, ttce_pkg::REQ_CLEAR_LINE, ttce_pkg::REQ_READ: immediate = 1'b0;
			ttce_pkg::REQ_BYTE: immediate = !bt_scroll;
			default: immediate = 1'b1;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sw_addr_q;
		ram_wdata = fill_q;
		ram_raddr = rd_addr;
		unique case (state_q)
			S_INIT, S_FILL: begin
				ram_we = 1'b1;
			end
			S_CLRL: begin
				ram_we = vld_s1;
				ram_waddr = addr_s1;
				ram_wdata = ttce_pkg::make_cell(ttce_pkg::BLANK, rd_cell.fore, rd_cell.back);
				ram_raddr = sw_addr_q;
			end
			S_FINISH: begin
				ram_we = pend_we_q;
				ram_waddr = pend_addr_q;
				ram_wdata = pend_data_q;
			end
			S_IDLE: begin
				ram_we = accept && (req_type == ttce_pkg::REQ_BYTE) && bt_print && !bt_scroll;
				ram_waddr = bt_addr;
				ram_wdata = ttce_pkg::make_cell(char_code[6:0], text_q, back_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ld_en = 1'b0;
		ld_row = 5'(cur_y_q);
		ld_col = 7'(cur_x_q);
		ld_code = '0;
		ld_fore = '0;
		ld_back = '0;
		ld_scroll = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ld_en = accept && immediate;
				ld_row = 5'(im_y);
				ld_col = 7'(im_x);
			end
			S_READ: begin
				ld_en = 1'b1;
				if (rd_ok_q) begin
					ld_code = rd_cell.code;
					ld_fore = rd_cell.fore;
					ld_back = rd_cell.back;
				end
			end
			S_FINISH: begin
				ld_en = 1'b1;
				ld_scroll = pend_scroll_q;
			end
			default: begin
			end
		endcase
	end

	ttce_ram #(
		.WIDTH(ttce_pkg::CELL_W),
		.DEPTH(DEPTH)
	) u_cells (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q <= ttce_pkg::RESET_FORE;
			back_q <= ttce_pkg::RESET_BACK;
			limit_q <= ttce_pkg::RESET_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ttce_pkg::CFG_TEXT: text_q <= cfg_wdata[2:0];
				ttce_pkg::CFG_BACK: back_q <= cfg_wdata[2:0];
				ttce_pkg::CFG_LIMIT: limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cur_x_q <= '0;
			cur_y_q <= '0;
			top_q <= '0;
			sw_addr_q <= '0;
			sw_end_q <= AW'(DEPTH - 1);
			fill_q <= ttce_pkg::make_cell(ttce_pkg::BLANK, ttce_pkg::RESET_FORE,
				ttce_pkg::RESET_BACK);
			rd_done_q <= 1'b1;
			vld_s1 <= 1'b0;
			pend_we_q <= 1'b0;
			pend_scroll_q <= 1'b0;
			rd_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (sw_addr_q == sw_end_q) begin
						state_q <= S_IDLE;
					end else begin
						sw_addr_q <= sw_addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						pend_we_q <= (req_type == ttce_pkg::REQ_BYTE) && bt_scroll && bt_print;
						pend_scroll_q <= (req_type == ttce_pkg::REQ_BYTE) && bt_scroll;
						rd_ok_q <= rd_ok;
						if (req_type == ttce_pkg::REQ_CLEAR) begin
							cur_x_q <= '0;
							cur_y_q <= '0;
							top_q <= '0;
						end else begin
							cur_x_q <= im_x;
							cur_y_q <= im_y;
							top_q <= im_top;
						end
						case (req_type)
							ttce_pkg::REQ_BYTE: begin
								if (bt_scroll) begin
									state_q <= S_FILL;
									fill_q <= new_blank;
									sw_addr_q <= sc_base;
									sw_end_q <= sc_base + AW'(COLS - 1);
								end
							end
							ttce_pkg::REQ_CLEAR: begin
								state_q <= S_FILL;
								fill_q <= new_blank;
								sw_addr_q <= '0;
								sw_end_q <= AW'(DEPTH - 1);
							end
							ttce_pkg::REQ_CLEAR_LINE: begin
								state_q <= S_CLRL;
								sw_addr_q <= cl_base;
								sw_end_q <= cl_base + AW'(COLS - 1);
								rd_done_q <= 1'b0;
							end
							ttce_pkg::REQ_READ: begin
								state_q <= S_READ;
							end
							default: begin
							end
						endcase
					end
				end
				S_FILL: begin
					if (sw_addr_q == sw_end_q) begin
						state_q <= S_FINISH;
					end else begin
						sw_addr_q <= sw_addr_q + AW'(1);
					end
				end
				S_CLRL: begin
					if (!rd_done_q) begin
						vld_s1 <= 1'b1;
						if (sw_addr_q == sw_end_q) begin
							rd_done_q <= 1'b1;
						end else begin
							sw_addr_q <= sw_addr_q + AW'(1);
						end
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= sw_addr_q;
		if (state_q == S_IDLE && accept) begin
			pend_addr_q <= bt_addr;
			pend_data_q <= ttce_pkg::make_cell(char_code[6:0], text_q, back_q);
		end
		if (ld_en) begin
			out_row_q <= ld_row;
			out_col_q <= ld_col;
			out_code_q <= ld_code;
			out_fore_q <= ld_fore;
			out_back_q <= ld_back;
			out_scroll_q <= ld_scroll;
		end
	end

	assign out_valid = out_valid_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;
	assign cell_code = out_code_q;
	assign cell_fore = out_fore_q;
	assign cell_back = out_back_q;
	assign did_scroll = out_scroll_q;

	a_read_waits_ram: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == ttce_pkg::REQ_READ) |=> (state_q == S_READ))
		else $error("cell read did not wait for the RAM data");

	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL || state_q == S_INIT) |-> (sw_addr_q <= sw_end_q))
		else $error("fill sweep ran past its last cell");

	a_rows_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cur_y_q) < 32'(ROWS)) && (32'(top_q) < 32'(ROWS)))
		else $error("cursor row or top offset out of range");

	a_finish_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished command gave no result beat");

endmodule

// ----- hw/rtl/ttce_ram.sv -----
module ttce_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 1920
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
